### src/nms4_pkg.sv
// Shared constants, types and helpers for the 4-neighbour non-maximum suppression block.
// No dependencies; compiled first.

package nms4_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int DATA_WIDTH   = 32;
	localparam int DIM_W        = 11;
	localparam int STORE_DEPTH  = 2 * MAX_WIDTH + 1;
	localparam int PTR_W        = $clog2(STORE_DEPTH);
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int POS_W        = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int CNT_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int ADDR_W       = 3;
	localparam int APB_DW       = 32;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int FIFO_DEPTH   = 3;
	localparam int FIFO_IDX_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [DIM_W-1:0] dim_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		data_t value;
		logic  eof;
	} result_t;

	typedef struct packed {
		logic  interior;
		logic  eof;
		logic  use_fwd;
		data_t fwd;
	} s1_ctrl_t;

	function automatic dim_t eff_dim(input dim_t v, input dim_t maxv);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### src/nms4_pixel_if.sv
// Input channel: pixel or drain beats with valid/ready handshake.
// Depends on nms4_pkg.

interface nms4_pixel_if import nms4_pkg::*; ();
	logic  valid;
	logic  ready;
	op_t   op;
	data_t pixel_value;

	modport source(output valid, output op, output pixel_value, input ready);
	modport sink(input valid, input op, input pixel_value, output ready);
endinterface

### src/nms4_result_if.sv
// Output channel: suppressed pixel beats with valid/ready handshake.
// Depends on nms4_pkg.

interface nms4_result_if import nms4_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t out_value;
	logic  end_of_frame;

	modport source(output valid, output out_value, output end_of_frame, input ready);
	modport sink(input valid, input out_value, input end_of_frame, output ready);
endinterface

### src/nonmax_suppression_4_neighbour.sv
// Each result is registered in stage s1 and then written into the result queue, which offers it.
// Throughput: one beat per cycle while ready is high; two line-store copies, each with two
// read ports, fetch center, right, up and down together, the left neighbor comes from the previous center.
// A 3-entry result queue decouples output stalls; input stalls only when it may overflow.
// Reset: counters cleared, frame 640 x 480; the line store is not cleared.

module nonmax_suppression_4_neighbour import nms4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	nms4_pixel_if.sink        pixels,
	nms4_result_if.source     results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	dim_t                  width_q, height_q, eff_w_q, eff_h_q;
	logic [CNT_W-1:0]      total_q, n_in_q;
	logic [POS_W-1:0]      out_index_q;
	logic [COL_W-1:0]      out_col_q;
	logic [ROW_W-1:0]      out_row_q;
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;

	data_t                 line_a_mem [STORE_DEPTH];
	data_t                 line_b_mem [STORE_DEPTH];

	logic                  valid_s1;
	s1_ctrl_t              ctrl_s1;
	data_t                 center_s1, right_s1, up_s1, down_s1;
	data_t                 left_q;

	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_IDX_W-1:0] fifo_wr_q, fifo_rd_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q;

	logic                  cfg_write;
	reg_idx_t              cfg_idx;
	dim_t                  cfg_dim;
	logic                  in_fire, is_pixel, store_en, emit_pix, emit_drain, emit;
	logic                  last_pos, interior, col_last;
	logic [PTR_W-1:0]      w_ptr, addr_right, addr_up, addr_down, wr_ptr_next, rd_ptr_next;
	logic [PTR_W:0]        sum_down;
	data_t                 down_val;
	logic                  suppress;
	logic                  push, pop;
	result_t               new_result;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(STORE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign cfg_write = psel & penable & pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[2]);
	assign cfg_dim   = pwdata[DIM_W-1:0];
	assign pready    = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign in_fire    = pixels.valid & pixels.ready;
	assign is_pixel   = (pixels.op == OP_PIXEL);
	assign store_en   = in_fire & is_pixel & (n_in_q < total_q);
	assign emit_pix   = store_en & (n_in_q >= CNT_W'(out_index_q) + CNT_W'(eff_w_q));
	assign emit_drain = in_fire & ~is_pixel & (n_in_q >= total_q)
		& (CNT_W'(out_index_q) < total_q);
	assign emit       = emit_pix | emit_drain;

	assign last_pos = (CNT_W'(out_index_q) == total_q - CNT_W'(1));
	assign col_last = (DIM_W'(out_col_q) == eff_w_q - dim_t'(1));
	assign interior = (out_row_q != '0) && (DIM_W'(out_row_q) != eff_h_q - dim_t'(1))
		&& (out_col_q != '0) && !col_last;

	assign w_ptr       = PTR_W'(eff_w_q);
	assign addr_right  = ptr_inc(rd_ptr_q);
	assign sum_down    = {1'b0, rd_ptr_q} + {1'b0, w_ptr};
	assign addr_down   = (sum_down >= (PTR_W+1)'(STORE_DEPTH))
		? PTR_W'(sum_down - (PTR_W+1)'(STORE_DEPTH)) : PTR_W'(sum_down);
	assign addr_up     = (rd_ptr_q >= w_ptr) ? rd_ptr_q - w_ptr
		: rd_ptr_q + PTR_W'(STORE_DEPTH) - w_ptr;
	assign wr_ptr_next = ptr_inc(wr_ptr_q);
	assign rd_ptr_next = ptr_inc(rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= dim_t'(RESET_WIDTH);
			height_q    <= dim_t'(RESET_HEIGHT);
			eff_w_q     <= dim_t'(RESET_WIDTH);
			eff_h_q     <= dim_t'(RESET_HEIGHT);
			total_q     <= CNT_W'(RESET_WIDTH * RESET_HEIGHT);
			n_in_q      <= '0;
			out_index_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_FRAME_WIDTH: begin
					width_q <= cfg_dim;
					eff_w_q <= eff_dim(cfg_dim, dim_t'(MAX_WIDTH));
					total_q <= CNT_W'(eff_dim(cfg_dim, dim_t'(MAX_WIDTH))) * CNT_W'(eff_h_q);
				end
				REG_FRAME_HEIGHT: begin
					height_q <= cfg_dim;
					eff_h_q  <= eff_dim(cfg_dim, dim_t'(MAX_HEIGHT));
					total_q  <= CNT_W'(eff_w_q) * CNT_W'(eff_dim(cfg_dim, dim_t'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
			n_in_q      <= '0;
			out_index_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
		end else begin
			if (store_en) begin
				n_in_q   <= n_in_q + CNT_W'(1);
				wr_ptr_q <= wr_ptr_next;
			end
			if (emit) begin
				if (last_pos) begin
					n_in_q      <= '0;
					out_index_q <= '0;
					out_col_q   <= '0;
					out_row_q   <= '0;
					wr_ptr_q    <= '0;
					rd_ptr_q    <= '0;
				end else begin
					out_index_q <= out_index_q + POS_W'(1);
					rd_ptr_q    <= rd_ptr_next;
					if (col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			line_a_mem[wr_ptr_q] <= pixels.pixel_value;
			line_b_mem[wr_ptr_q] <= pixels.pixel_value;
		end
		if (emit) begin
			center_s1 <= line_a_mem[rd_ptr_q];
			right_s1  <= line_a_mem[addr_right];
			up_s1     <= line_b_mem[addr_up];
			down_s1   <= line_b_mem[addr_down];
			ctrl_s1   <= '{interior: interior, eof: last_pos, use_fwd: is_pixel,
				fwd: pixels.pixel_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit;
		end
	end

	// the down neighbor of a pixel-triggered beat is the pixel being written now
	assign down_val = ctrl_s1.use_fwd ? ctrl_s1.fwd : down_s1;
	assign suppress = ctrl_s1.interior & ((up_s1 >= center_s1) | (left_q >= center_s1)
		| (right_s1 >= center_s1) | (down_val >= center_s1));
	assign new_result = '{value: suppress ? data_t'(0) : center_s1, eof: ctrl_s1.eof};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_q <= center_s1;
		end
		if (push) begin
			fifo_q[fifo_wr_q] <= new_result;
		end
	end

	assign push = valid_s1;
	assign pop  = results.valid & results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wr_q  <= '0;
			fifo_rd_q  <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				fifo_wr_q <= (fifo_wr_q == FIFO_IDX_W'(FIFO_DEPTH - 1))
					? '0 : fifo_wr_q + FIFO_IDX_W'(1);
			end
			if (pop) begin
				fifo_rd_q <= (fifo_rd_q == FIFO_IDX_W'(FIFO_DEPTH - 1))
					? '0 : fifo_rd_q + FIFO_IDX_W'(1);
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	// hold input while the queue could not absorb everything in flight
	assign pixels.ready = ((FIFO_CNT_W+1)'(fifo_cnt_q) + (FIFO_CNT_W+1)'(valid_s1))
		< (FIFO_CNT_W+1)'(FIFO_DEPTH);

	assign results.valid        = (fifo_cnt_q != '0);
	assign results.out_value    = fifo_q[fifo_rd_q].value;
	assign results.end_of_frame = fifo_q[fifo_rd_q].eof;

endmodule
